>>> rtl/spoc_pkg.sv
`timescale 1ns / 1ps

package spoc_pkg;

    // defaults for the top level parameters
    localparam int MAX_SPHERES_DEF = 64;
    localparam int OWNER_BITS_DEF  = 16;

    // fixed field widths
    localparam int SLOT_W   = 6;
    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int OWNER_W  = 16;
    localparam int COUNT_W  = 7;

    // squared terms are Q32.32, three of them need two extra bits
    localparam int PROD_W = 2 * COORD_W;
    localparam int ACC_W  = PROD_W + 2;

    // input word kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TEST  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LATCH_I,
        ST_FETCH,
        ST_DX,
        ST_DY,
        ST_DZ,
        ST_RS,
        ST_MR,
        ST_CMP,
        ST_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        OPS_DX,
        OPS_DY,
        OPS_DZ,
        OPS_RS
    } op_sel_t;

    typedef struct packed {
        logic    op_load;
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctrl_t;

endpackage

>>> rtl/spoc_store.sv
`timescale 1ns / 1ps

module spoc_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 143
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/spoc_mac.sv
`timescale 1ns / 1ps

module spoc_mac (
    input  logic                    clk,
    input  spoc_pkg::mac_ctrl_t     ctrl,
    input  logic [spoc_pkg::COORD_W-1:0] operand,
    output logic                    le
);

    import spoc_pkg::*;

    logic [COORD_W-1:0] op_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]   acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.op_load)
        begin
            op_reg <= operand;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(op_reg) * PROD_W'(op_reg);
        end
        case (ctrl.acc_op)
            ACC_LOAD: acc_reg <= ACC_W'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            default:  acc_reg <= acc_reg;
        endcase
    end

    // sum of squared distances against squared radius sum
    assign le = (acc_reg <= ACC_W'(prod_reg));

endmodule

>>> rtl/sphere_pair_overlap_check_unit.sv
// Sphere pair overlap check. A table of up to MAX_SPHERES bounding spheres
// (centre in signed Q16.16, radius in unsigned Q15.16, owner id) is loaded one
// slot per write word (mode 0, no result). A test word (mode 1) names a slot
// and walks active slots 0 .. min(active_count, MAX_SPHERES)-1 in ascending
// order, skipping itself, emitting one result word per overlapping partner
// (touching counts) with last set on the final one, or a single no-hit word
// when none overlaps or the tested slot is not active. The compare is exact
// in Q32.32. The input is stalled for the whole test: the tested sphere is
// fetched, each partner takes a fetch, the dx, dy, dz and radius sum steps,
// a product step and the compare, the own slot only a fetch, then the walk
// end is seen and the last word finished (an inactive tested slot goes
// straight to the finish). The single 32x32 squaring multiplier forms dx^2,
// dy^2, dz^2 and (ri + rj)^2 one after another for each pair. A hit found
// while an earlier one is held and the output is stalled holds the walk.
// Load the table and active_count only while no test is in progress.
`timescale 1ns / 1ps

module sphere_pair_overlap_check_unit #(
    parameter int MAX_SPHERES = spoc_pkg::MAX_SPHERES_DEF,
    parameter int OWNER_BITS  = spoc_pkg::OWNER_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [spoc_pkg::COUNT_W-1:0]        cfg_wr_data,
    // input words
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [spoc_pkg::SLOT_W-1:0]         slot,
    input  logic signed [spoc_pkg::COORD_W-1:0] pos_x,
    input  logic signed [spoc_pkg::COORD_W-1:0] pos_y,
    input  logic signed [spoc_pkg::COORD_W-1:0] pos_z,
    input  logic [spoc_pkg::RADIUS_W-1:0]       radius,
    input  logic [spoc_pkg::OWNER_W-1:0]        owner_id,
    // result words
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic [spoc_pkg::OWNER_W-1:0]        tested_owner,
    output logic [spoc_pkg::SLOT_W-1:0]         other_slot,
    output logic                                last
);

    import spoc_pkg::*;

    localparam int IDX_W   = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CNT_W   = $clog2(MAX_SPHERES + 1);
    localparam int ENTRY_W = 3 * COORD_W + RADIUS_W + OWNER_BITS;
    // entry layout {x, y, z, r, owner}
    localparam int OWN_LSB = 0;
    localparam int R_LSB   = OWN_LSB + OWNER_BITS;
    localparam int Z_LSB   = R_LSB + RADIUS_W;
    localparam int Y_LSB   = Z_LSB + COORD_W;
    localparam int X_LSB   = Y_LSB + COORD_W;

    // |a - b| of two signed values, always fits the unsigned width
    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        begin
            d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
            abs_diff = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
        end
    endfunction

    // control state
    seq_state_t               state_reg, state_next;
    logic [COUNT_W-1:0]       active_count_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic                     in_range_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]         pend_slot_reg, pend_slot_next;
    logic                     out_valid_reg, out_valid_next;

    // tested sphere
    logic signed [COORD_W-1:0] xi_reg, yi_reg, zi_reg;
    logic [RADIUS_W-1:0]       ri_reg;
    logic [OWNER_BITS-1:0]     owner_i_reg;

    // result word
    logic                 hit_reg, hit_next;
    logic [SLOT_W-1:0]    other_reg, other_next;
    logic                 last_reg, last_next;
    logic [OWNER_BITS-1:0] owner_reg;
    logic                 emit;

    // table access
    logic                 in_accept;
    logic                 slot_ok;
    logic                 wr_en;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic [ENTRY_W-1:0]   rd_data;

    // pair arithmetic
    mac_ctrl_t            mac_ctrl;
    op_sel_t              op_sel;
    logic [COORD_W-1:0]   operand;
    logic                 le;

    logic                 out_free;
    logic                 walk_done;
    logic                 is_self;
    logic                 slot_active;
    logic                 cmp_hold;
    logic [CNT_W-1:0]     n_clamped;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign slot_ok     = int'(slot) < MAX_SPHERES;
    assign walk_done   = (j_reg == n_reg);
    assign is_self     = int'(j_reg) == int'(slot_reg);
    assign slot_active = int'(slot_reg) < int'(n_reg);
    assign cmp_hold    = le && pend_valid_reg && !out_free;
    assign n_clamped   = (int'(active_count_reg) > MAX_SPHERES) ?
                         CNT_W'(MAX_SPHERES) : CNT_W'(active_count_reg);

    // table
    assign wr_en   = in_accept && (mode == MODE_WRITE) && slot_ok;
    assign wr_data = {pos_x, pos_y, pos_z, radius, OWNER_BITS'(owner_id)};
    assign rd_addr = (state_reg == ST_IDLE) ? IDX_W'(slot) : j_reg[IDX_W-1:0];

    spoc_store #(
        .DEPTH  (MAX_SPHERES),
        .ADDR_W (IDX_W),
        .WIDTH  (ENTRY_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(slot)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // operand for the squaring unit, partner comes straight from the read register
    always_comb
    begin
        case (op_sel)
            OPS_DX:  operand = abs_diff(xi_reg, $signed(rd_data[X_LSB +: COORD_W]));
            OPS_DY:  operand = abs_diff(yi_reg, $signed(rd_data[Y_LSB +: COORD_W]));
            OPS_DZ:  operand = abs_diff(zi_reg, $signed(rd_data[Z_LSB +: COORD_W]));
            OPS_RS:  operand = {1'b0, ri_reg} + {1'b0, rd_data[R_LSB +: RADIUS_W]};
            default: operand = '0;
        endcase
    end

    spoc_mac u_mac (
        .clk     (clk),
        .ctrl    (mac_ctrl),
        .operand (operand),
        .le      (le)
    );

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (mode == MODE_TEST))
                begin
                    state_next = ST_LATCH_I;
                end
            end
            ST_LATCH_I:
            begin
                // out of table or not active: straight to the no-hit word
                if (!in_range_reg || !slot_active)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (walk_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (!is_self)
                begin
                    state_next = ST_DX;
                end
            end
            ST_DX: state_next = ST_DY;
            ST_DY: state_next = ST_DZ;
            ST_DZ: state_next = ST_RS;
            ST_RS: state_next = ST_MR;
            ST_MR: state_next = ST_CMP;
            ST_CMP:
            begin
                if (!cmp_hold)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        mac_ctrl        = '{op_load: 1'b0, mul_en: 1'b0, acc_op: ACC_HOLD};
        op_sel          = OPS_DX;
        rd_en           = 1'b0;
        j_next          = j_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        emit            = 1'b0;
        hit_next        = hit_reg;
        other_next      = other_reg;
        last_next       = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                rd_en = in_accept && (mode == MODE_TEST);
            end
            ST_LATCH_I:
            begin
                j_next          = '0;
                pend_valid_next = 1'b0;
            end
            ST_FETCH:
            begin
                if (!walk_done)
                begin
                    if (is_self)
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            ST_DX:
            begin
                mac_ctrl = '{op_load: 1'b1, mul_en: 1'b0, acc_op: ACC_HOLD};
                op_sel   = OPS_DX;
            end
            ST_DY:
            begin
                mac_ctrl = '{op_load: 1'b1, mul_en: 1'b1, acc_op: ACC_HOLD};
                op_sel   = OPS_DY;
            end
            ST_DZ:
            begin
                mac_ctrl = '{op_load: 1'b1, mul_en: 1'b1, acc_op: ACC_LOAD};
                op_sel   = OPS_DZ;
            end
            ST_RS:
            begin
                mac_ctrl = '{op_load: 1'b1, mul_en: 1'b1, acc_op: ACC_ADD};
                op_sel   = OPS_RS;
            end
            ST_MR:
            begin
                mac_ctrl = '{op_load: 1'b0, mul_en: 1'b1, acc_op: ACC_ADD};
            end
            ST_CMP:
            begin
                if (!cmp_hold)
                begin
                    j_next = j_reg + 1'b1;
                    if (le)
                    begin
                        // a newer hit means the held one is not the last
                        if (pend_valid_reg)
                        begin
                            emit       = 1'b1;
                            hit_next   = 1'b1;
                            other_next = SLOT_W'(pend_slot_reg);
                            last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = j_reg;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    hit_next        = pend_valid_reg;
                    other_next      = pend_valid_reg ? SLOT_W'(pend_slot_reg) : '0;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign out_valid_next = emit ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            active_count_reg <= '0;
            slot_reg         <= '0;
            in_range_reg     <= 1'b0;
            n_reg            <= '0;
            j_reg            <= '0;
            pend_valid_reg   <= 1'b0;
            pend_slot_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            j_reg          <= j_next;
            pend_valid_reg <= pend_valid_next;
            pend_slot_reg  <= pend_slot_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                active_count_reg <= cfg_wr_data;
            end
            if (in_accept && (mode == MODE_TEST))
            begin
                slot_reg     <= slot;
                in_range_reg <= slot_ok;
                n_reg        <= n_clamped;
            end
        end
    end

    // tested sphere and result word
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LATCH_I)
        begin
            xi_reg      <= $signed(rd_data[X_LSB +: COORD_W]);
            yi_reg      <= $signed(rd_data[Y_LSB +: COORD_W]);
            zi_reg      <= $signed(rd_data[Z_LSB +: COORD_W]);
            ri_reg      <= rd_data[R_LSB +: RADIUS_W];
            owner_i_reg <= in_range_reg ? rd_data[OWN_LSB +: OWNER_BITS] : '0;
        end
        if (emit)
        begin
            hit_reg   <= hit_next;
            other_reg <= other_next;
            last_reg  <= last_next;
            // owner travels with the word, the next test may start while it waits
            owner_reg <= owner_i_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign tested_owner = OWNER_W'(owner_reg);
    assign other_slot   = other_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    // the walk never runs past the active slots
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> (j_reg <= n_reg))
        else $error("slot walk past active count");

    // a held hit is always an active partner other than the tested slot
    a_pend_slot: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> ((pend_slot_reg < n_reg) &&
                            (int'(pend_slot_reg) != int'(slot_reg))))
        else $error("held hit names a bad slot");

    // a word without last only goes out while a later hit is held
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> pend_valid_reg)
        else $error("non-final word with no following hit");
`endif

endmodule

>>> verif/sphere_pair_overlap_check_unit_tb.sv
`timescale 1ns / 1ps

module sphere_pair_overlap_check_unit_tb;

    import spoc_pkg::*;

    localparam int          MAX_SPH       = MAX_SPHERES_DEF;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          DRAIN_CYCLES  = 7 * MAX_SPHERES_DEF + 16;
    localparam int          PHASE_WORDS   = 126;
    localparam int          DIR_ROWS      = 25;
    localparam logic [31:0] Q_ONE         = 32'h0001_0000;
    localparam logic [30:0] R_ONE         = 31'h0001_0000;
    localparam logic [30:0] R_MAX         = 31'h7FFF_FFFF;
    // cluster spheres sit within +-4.0 and have radii up to 2.0
    localparam logic [31:0] SPAN          = 32'h0004_0000;
    localparam int          R_SPREAD      = 32'h0002_0000;

    typedef enum logic {
        ROW_CFG,
        ROW_WORD
    } row_kind_t;

    typedef struct packed {
        logic                md;
        logic [SLOT_W-1:0]   sl;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [RADIUS_W-1:0] r;
        logic [OWNER_W-1:0]  own;
    } in_word_t;

    typedef struct packed {
        logic               hit;
        logic [OWNER_W-1:0] owner;
        logic [SLOT_W-1:0]  other;
        logic               last;
    } overlap_word_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [COUNT_W-1:0]  count;
        logic                md;
        logic [SLOT_W-1:0]   sl;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [RADIUS_W-1:0] r;
        logic [OWNER_W-1:0]  own;
        bit                  typed;
        logic                t_hit;
        logic [OWNER_W-1:0]  t_own;
        logic [SLOT_W-1:0]   t_other;
        logic                t_last;
    } row_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic [COUNT_W-1:0]  cfg_wr_data  = '0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic                mode         = MODE_WRITE;
    logic [SLOT_W-1:0]   slot         = '0;
    logic [COORD_W-1:0]  pos_x        = '0;
    logic [COORD_W-1:0]  pos_y        = '0;
    logic [COORD_W-1:0]  pos_z        = '0;
    logic [RADIUS_W-1:0] radius       = '0;
    logic [OWNER_W-1:0]  owner_id     = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                hit;
    logic [OWNER_W-1:0]  tested_owner;
    logic [SLOT_W-1:0]   other_slot;
    logic                last;

    // shadow copy of the sphere table and the active count
    logic [COORD_W-1:0]  cx_store  [MAX_SPH];
    logic [COORD_W-1:0]  cy_store  [MAX_SPH];
    logic [COORD_W-1:0]  cz_store  [MAX_SPH];
    logic [RADIUS_W-1:0] rad_store [MAX_SPH];
    logic [OWNER_W-1:0]  own_store [MAX_SPH];
    logic [COUNT_W-1:0]  active_cnt = '0;

    overlap_word_t pending_overlaps [$];
    overlap_word_t got_w;
    overlap_word_t want_w;

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int mismatch_cnt = 0;
    int result_cnt   = 0;
    int overlap_cnt  = 0;
    int load_cnt     = 0;
    int test_cnt     = 0;
    int count_writes = 0;

    row_t directed_rows [DIR_ROWS];

    sphere_pair_overlap_check_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .slot         (slot),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .radius       (radius),
        .owner_id     (owner_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .tested_owner (tested_owner),
        .other_slot   (other_slot),
        .last         (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // |a - b| of two signed coordinates, always fits 32 bits
    function automatic logic [31:0] abs_delta(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        if (d < 0)
            d = -d;
        return d[31:0];
    endfunction

    // exact squared compare, wide enough that nothing wraps
    function automatic bit spheres_meet(input int i, input int j);
        logic [65:0] dx;
        logic [65:0] dy;
        logic [65:0] dz;
        logic [65:0] rs;
        dx = {34'd0, abs_delta(cx_store[i], cx_store[j])};
        dy = {34'd0, abs_delta(cy_store[i], cy_store[j])};
        dz = {34'd0, abs_delta(cz_store[i], cz_store[j])};
        rs = {35'd0, rad_store[i]} + {35'd0, rad_store[j]};
        return (dx * dx + dy * dy + dz * dz) <= (rs * rs);
    endfunction

    function automatic logic [31:0] pick_coord(input int style);
        logic [31:0] c;
        if (style == 0)
            c = $urandom;
        else if (style == 1)
        begin
            case ($urandom_range(3))
                0:       c = 32'h8000_0000;
                1:       c = 32'h7FFF_FFFF;
                2:       c = 32'h0000_0000;
                default: c = 32'hFFFF_FFFF;
            endcase
        end
        else
            c = 32'($urandom_range(2 * SPAN)) - SPAN;
        return c;
    endfunction

    // mostly clustered spheres so tests see a handful of overlaps,
    // with some fully random and some corner-valued ones as noise
    function automatic in_word_t random_load(input logic [SLOT_W-1:0] s);
        in_word_t w;
        int       style;
        style = $urandom_range(9);
        w.md  = MODE_WRITE;
        w.sl  = s;
        w.x   = pick_coord(style);
        w.y   = pick_coord(style);
        w.z   = pick_coord(style);
        w.own = 16'($urandom);
        if (style == 0)
            w.r = 31'($urandom);
        else if (style == 1)
            w.r = $urandom_range(1) ? R_MAX : 31'd0;
        else
            w.r = 31'($urandom_range(R_SPREAD));
        return w;
    endfunction

    // update the shadow table, or work out the result words of a test
    task automatic predict_word(input in_word_t w);
        int n;
        int k;
        int partners [$];
        overlap_word_t res;
        if (w.md == MODE_WRITE)
        begin
            cx_store[w.sl]  = w.x;
            cy_store[w.sl]  = w.y;
            cz_store[w.sl]  = w.z;
            rad_store[w.sl] = w.r;
            own_store[w.sl] = w.own;
            load_cnt++;
            return;
        end
        test_cnt++;
        n = (int'(active_cnt) > MAX_SPH) ? MAX_SPH : int'(active_cnt);
        if (int'(w.sl) < n)
        begin
            for (k = 0; k < n; k++)
            begin
                if (k != int'(w.sl) && spheres_meet(int'(w.sl), k))
                    partners.push_back(k);
            end
        end
        res.owner = own_store[w.sl];
        if (partners.size() == 0)
        begin
            res.hit   = 1'b0;
            res.other = '0;
            res.last  = 1'b1;
            pending_overlaps.push_back(res);
        end
        else
        begin
            for (k = 0; k < partners.size(); k++)
            begin
                res.hit   = 1'b1;
                res.other = 6'(partners[k]);
                res.last  = (k == partners.size() - 1);
                pending_overlaps.push_back(res);
            end
        end
    endtask

    // present one word and hold it until the block takes it
    task automatic send_word(input in_word_t w);
        bit taken;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= w.md;
        slot     <= w.sl;
        pos_x    <= w.x;
        pos_y    <= w.y;
        pos_z    <= w.z;
        radius   <= w.r;
        owner_id <= w.own;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
        end
        @(posedge clk);
    endtask

    // the count only changes once every result word is back and the walk is over
    task automatic set_active(input logic [COUNT_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_overlaps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        active_cnt = v;
        count_writes++;
    endtask

    // result words are checked at the falling edge, where the handshake is settled
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_w = '{hit, tested_owner, other_slot, last};
            result_cnt++;
            if (hit)
                overlap_cnt++;
            if (pending_overlaps.size() == 0)
            begin
                if (mismatch_cnt < 10)
                    $display("%0t: unexpected word hit=%0b owner=%h other=%0d last=%0b",
                             $realtime, got_w.hit, got_w.owner, got_w.other, got_w.last);
                mismatch_cnt++;
            end
            else
            begin
                want_w = pending_overlaps.pop_front();
                if (got_w.hit !== want_w.hit || got_w.owner !== want_w.owner ||
                    got_w.other !== want_w.other || got_w.last !== want_w.last)
                begin
                    if (mismatch_cnt < 10)
                        $display("%0t: want hit=%0b owner=%h other=%0d last=%0b, %s%0b %s%h %s%0d %s%0b",
                                 $realtime, want_w.hit, want_w.owner, want_w.other,
                                 want_w.last, "got hit=", got_w.hit, "owner=", got_w.owner,
                                 "other=", got_w.other, "last=", got_w.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int       k;
        int       ph;
        int       phase_words;
        int       n_eff;
        int       round_len;
        in_word_t w;

        directed_rows = '{
            // empty table, then a lone sphere
            '{ROW_WORD, 7'd0, MODE_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, R_ONE, 16'h1234,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_WORD, 7'd0, MODE_TEST, 6'd0, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b1, 1'b0, 16'h1234, 6'd0, 1'b1},
            '{ROW_CFG, 7'd1, MODE_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_WORD, 7'd0, MODE_TEST, 6'd0, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b1, 1'b0, 16'h1234, 6'd0, 1'b1},
            // touching along x counts as a hit both ways
            '{ROW_WORD, 7'd0, MODE_WRITE, 6'd1, 2 * Q_ONE, 32'h0, 32'h0, R_ONE, 16'hFFFF,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_CFG, 7'd2, MODE_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_WORD, 7'd0, MODE_TEST, 6'd0, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b1, 1'b1, 16'h1234, 6'd1, 1'b1},
            '{ROW_WORD, 7'd0, MODE_TEST, 6'd1, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b1, 1'b1, 16'hFFFF, 6'd0, 1'b1},
            // one lsb apart
            '{ROW_WORD, 7'd0, MODE_WRITE, 6'd1, 2 * Q_ONE + 1, 32'h0, 32'h0, R_ONE, 16'hFFFF,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_WORD, 7'd0, MODE_TEST, 6'd0, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b1, 1'b0, 16'h1234, 6'd0, 1'b1},
            // opposite corners of the coordinate range
            '{ROW_WORD, 7'd0, MODE_WRITE, 6'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              31'h0, 16'h0000, 1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_WORD, 7'd0, MODE_WRITE, 6'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              R_MAX, 16'hA5A5, 1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_CFG, 7'd4, MODE_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_WORD, 7'd0, MODE_TEST, 6'd2, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_WORD, 7'd0, MODE_TEST, 6'd3, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            // largest radius at the origin
            '{ROW_WORD, 7'd0, MODE_WRITE, 6'd2, 32'h0, 32'h0, 32'h0, R_MAX, 16'h0000,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_WORD, 7'd0, MODE_TEST, 6'd2, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_WORD, 7'd0, MODE_TEST, 6'd3, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            // tested slot not active
            '{ROW_CFG, 7'd3, MODE_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_WORD, 7'd0, MODE_TEST, 6'd3, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b1, 1'b0, 16'hA5A5, 6'd0, 1'b1},
            '{ROW_WORD, 7'd0, MODE_WRITE, 6'd3, 32'hFFFF_0000, 32'h0, 32'h0, R_ONE, 16'h00FF,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_CFG, 7'd4, MODE_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_WORD, 7'd0, MODE_TEST, 6'd0, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            // touching along z
            '{ROW_WORD, 7'd0, MODE_WRITE, 6'd1, 32'h0, 32'h0, 2 * Q_ONE, R_ONE, 16'hFFFF,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0},
            '{ROW_WORD, 7'd0, MODE_TEST, 6'd1, 32'h0, 32'h0, 32'h0, 31'h0, 16'h0,
              1'b0, 1'b0, 16'h0, 6'd0, 1'b0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 27;
        rx_idle_pct = 78;
        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (directed_rows[k].kind == ROW_CFG)
                set_active(directed_rows[k].count);
            else
            begin
                w = '{directed_rows[k].md, directed_rows[k].sl, directed_rows[k].x,
                      directed_rows[k].y, directed_rows[k].z, directed_rows[k].r,
                      directed_rows[k].own};
                send_word(w);
                if (directed_rows[k].typed)
                begin
                    pending_overlaps.push_back('{directed_rows[k].t_hit, directed_rows[k].t_own,
                                                 directed_rows[k].t_other,
                                                 directed_rows[k].t_last});
                    test_cnt++;
                end
                else
                    predict_word(w);
            end
        end

        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 27;
                    rx_idle_pct = 78;
                end
                1:
                begin
                    tx_idle_pct = 78;
                    rx_idle_pct = 27;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            phase_words = 0;
            // fill the whole table first so no test ever reads an unwritten slot
            if (ph == 0)
            begin
                for (k = 0; k < MAX_SPH; k++)
                begin
                    w = random_load(6'(k));
                    send_word(w);
                    predict_word(w);
                end
                phase_words = MAX_SPH;
            end
            // each round drains the block, sets a new count, then mixes loads and tests
            while (phase_words < PHASE_WORDS)
            begin
                case ($urandom_range(9))
                    0:       set_active(7'd0);
                    1:       set_active(7'd1);
                    2:       set_active(7'd2);
                    3:       set_active(7'd64);
                    4:       set_active(7'd127);
                    5:       set_active(7'($urandom));
                    default: set_active(7'($urandom_range(3, 24)));
                endcase
                n_eff = (int'(active_cnt) > MAX_SPH) ? MAX_SPH : int'(active_cnt);
                round_len = $urandom_range(6, 18);
                repeat (round_len)
                begin
                    w = random_load(6'($urandom));
                    if ($urandom_range(99) >= 35)
                    begin
                        w.md = MODE_TEST;
                        if (n_eff > 0 && $urandom_range(99) < 80)
                            w.sl = 6'($urandom_range(n_eff - 1));
                    end
                    send_word(w);
                    predict_word(w);
                    phase_words++;
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_overlaps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d loads, %0d overlap tests, %0d active count settings",
                 load_cnt, test_cnt, count_writes);
        $display("checked %0d result words, %0d overlaps among them, %0d mismatches",
                 result_cnt, overlap_cnt, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/spoc_pkg.sv
rtl/spoc_store.sv
rtl/spoc_mac.sv
rtl/sphere_pair_overlap_check_unit.sv
verif/sphere_pair_overlap_check_unit_tb.sv
